[rtl/fsas_pkg.sv]
// Shared types and constants for the flag-setting ALU and shifter.
// No dependencies; used by every module under rtl/.
package fsas_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned SHAMT_W = 5;

	typedef enum logic [3:0] {
		KIND_ADD    = 4'd0,
		KIND_ADC    = 4'd1,
		KIND_SUB    = 4'd2,
		KIND_SBC    = 4'd3,
		KIND_SHL    = 4'd4,
		KIND_SHR    = 4'd5,
		KIND_SAR    = 4'd6,
		KIND_SHL_CC = 4'd7,
		KIND_SHR_CC = 4'd8,
		KIND_SAR_CC = 4'd9,
		KIND_ROR_CC = 4'd10
	} kind_t;

	// n in bit 0, v in bit 3
	typedef struct packed {
		logic v;
		logic c;
		logic z;
		logic n;
	} flags_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		flags_t            flags;
	} alu_out_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              carry_we;
		logic              carry;
	} shift_out_t;

endpackage

[rtl/fsas_alu.sv]
// Adder/subtractor with carry-in and full NZCV flag generation.
// Depends on fsas_pkg.
module fsas_alu (
	input  fsas_pkg::kind_t                 kind,
	input  logic [fsas_pkg::WORD_W-1:0]     operand_a,
	input  logic [fsas_pkg::WORD_W-1:0]     operand_b,
	input  logic                            carry_in,
	output fsas_pkg::alu_out_t              alu_out
);

	logic                          is_sub;
	logic                          cin;
	logic [fsas_pkg::WORD_W-1:0]   b_op;
	logic [fsas_pkg::WORD_W:0]     sum;
	logic [fsas_pkg::WORD_W-1:0]   res;
	logic [fsas_pkg::WORD_W-1:0]   ovf_vec;

	// subtract is a + ~b + 1; borrow-in uses the inverted-carry convention
	assign is_sub = (kind == fsas_pkg::KIND_SUB) || (kind == fsas_pkg::KIND_SBC);
	assign b_op   = is_sub ? ~operand_b : operand_b;
	assign cin    = ((kind == fsas_pkg::KIND_ADC) || (kind == fsas_pkg::KIND_SBC)) ?
	                carry_in : is_sub;
	assign sum    = {1'b0, operand_a} + {1'b0, b_op}
	              + {{fsas_pkg::WORD_W{1'b0}}, cin};
	assign res    = sum[fsas_pkg::WORD_W-1:0];
	assign ovf_vec = ~(operand_a ^ b_op) & (operand_a ^ res);

	always_comb begin
		alu_out.result  = res;
		alu_out.flags.n = res[fsas_pkg::WORD_W-1];
		alu_out.flags.z = (res == '0);
		alu_out.flags.c = sum[fsas_pkg::WORD_W];
		alu_out.flags.v = ovf_vec[fsas_pkg::WORD_W-1];
	end

endmodule

[rtl/fsas_shifter.sv]
// Barrel shifter for the plain and carry-setting shift and rotate kinds.
// Depends on fsas_pkg.
module fsas_shifter (
	input  fsas_pkg::kind_t                 kind,
	input  logic [fsas_pkg::WORD_W-1:0]     operand_a,
	input  logic [fsas_pkg::COUNT_W-1:0]    count,
	output fsas_pkg::shift_out_t            shift_out
);

	logic                            big;
	logic                            exact;
	logic                            nonzero;
	logic [fsas_pkg::SHAMT_W-1:0]    shamt;
	logic [fsas_pkg::SHAMT_W-1:0]    shamt_sar;
	logic [fsas_pkg::WORD_W:0]       lsh;
	logic [fsas_pkg::WORD_W:0]       rsh;
	logic signed [fsas_pkg::WORD_W:0] ash;
	logic [2*fsas_pkg::WORD_W-1:0]   ror;
	logic                            msb;

	assign big       = |count[fsas_pkg::COUNT_W-1:fsas_pkg::SHAMT_W];
	assign exact     = (count == fsas_pkg::COUNT_W'(fsas_pkg::WORD_W));
	assign nonzero   = |count;
	assign shamt     = count[fsas_pkg::SHAMT_W-1:0];
	assign shamt_sar = big ? {fsas_pkg::SHAMT_W{1'b1}} : shamt;
	assign msb       = operand_a[fsas_pkg::WORD_W-1];

	// extra bit on each side catches the last bit shifted out
	assign lsh = {1'b0, operand_a} << shamt;
	assign rsh = {operand_a, 1'b0} >> shamt;
	assign ash = $signed({operand_a, 1'b0}) >>> shamt_sar;
	assign ror = {operand_a, operand_a} >> shamt;

	always_comb begin
		shift_out.result   = operand_a;
		shift_out.carry_we = 1'b0;
		shift_out.carry    = 1'b0;
		case (kind)
			fsas_pkg::KIND_SHL: begin
				shift_out.result = big ? '0 : lsh[fsas_pkg::WORD_W-1:0];
			end
			fsas_pkg::KIND_SHR: begin
				shift_out.result = big ? '0 : rsh[fsas_pkg::WORD_W:1];
			end
			fsas_pkg::KIND_SAR: begin
				shift_out.result = ash[fsas_pkg::WORD_W:1];
			end
			fsas_pkg::KIND_SHL_CC: begin
				if (big) begin
					shift_out.result   = '0;
					shift_out.carry_we = 1'b1;
					shift_out.carry    = exact & operand_a[0];
				end else if (nonzero) begin
					shift_out.result   = lsh[fsas_pkg::WORD_W-1:0];
					shift_out.carry_we = 1'b1;
					shift_out.carry    = lsh[fsas_pkg::WORD_W];
				end
			end
			fsas_pkg::KIND_SHR_CC: begin
				if (big) begin
					shift_out.result   = '0;
					shift_out.carry_we = 1'b1;
					shift_out.carry    = exact & msb;
				end else if (nonzero) begin
					shift_out.result   = rsh[fsas_pkg::WORD_W:1];
					shift_out.carry_we = 1'b1;
					shift_out.carry    = rsh[0];
				end
			end
			fsas_pkg::KIND_SAR_CC: begin
				if (nonzero) begin
					shift_out.result   = ash[fsas_pkg::WORD_W:1];
					shift_out.carry_we = 1'b1;
					shift_out.carry    = big ? msb : ash[0];
				end
			end
			fsas_pkg::KIND_ROR_CC: begin
				// rotate by a nonzero multiple of 32 keeps the word, C takes bit 31
				if (shamt == '0) begin
					shift_out.carry_we = nonzero;
					shift_out.carry    = msb;
				end else begin
					shift_out.result   = ror[fsas_pkg::WORD_W-1:0];
					shift_out.carry_we = 1'b1;
					shift_out.carry    = rsh[0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/flag_setting_alu_and_shifter.sv]
// Top level: 32-bit ALU and barrel shifter keeping N, Z, C, V flags.
// Depends on fsas_pkg, fsas_alu, fsas_shifter.
//
//  channel | dir | tdata                              | tuser
//  --------+-----+------------------------------------+----------------------------
//  s_*     | in  | [31:0] operand_a, [63:32] operand_b | [3:0] kind
//  m_*     | out | [31:0] result                       | [0] N [1] Z [2] C [3] V
//
// One request per cycle sustained unless the output stalls; an item passes the
// input register, then the result register, with the adder and the shifter
// between the two; the flag register updates as an item moves into the result
// register, so the next item (adc/sbc) sees the new carry with no bubble.
// arst_n clears both valid bits and all four flags; payload regs are not reset.
// A stalled output holds the result register; the input register still loads
// while it is empty, or while the result register is free or being drained.
module flag_setting_alu_and_shifter (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
	input  logic [3:0]  s_tuser,   // [3:0] kind

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result
	output logic [3:0]  m_tuser    // [0] negative, [1] zero, [2] carry, [3] overflow
);

	localparam int unsigned W = fsas_pkg::WORD_W;

	// input stage
	logic                         valid_s1;
	fsas_pkg::kind_t              kind_s1;
	logic [W-1:0]                 a_s1;
	logic [W-1:0]                 b_s1;

	// result stage
	logic                         valid_s2;
	logic [W-1:0]                 result_s2;

	// architectural flags; always equal the flags of the item in the result stage
	fsas_pkg::flags_t             flag_q;

	fsas_pkg::alu_out_t           alu_out;
	fsas_pkg::shift_out_t         shift_out;
	logic [W-1:0]                 res_nxt;
	fsas_pkg::flags_t             flags_nxt;
	logic                         accept;
	logic                         advance;

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign accept   = s_tvalid & s_tready;

	fsas_alu u_alu (
		.kind      (kind_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.carry_in  (flag_q.c),
		.alu_out   (alu_out)
	);

	fsas_shifter u_shifter (
		.kind      (kind_s1),
		.operand_a (a_s1),
		.count     (b_s1[fsas_pkg::COUNT_W-1:0]),
		.shift_out (shift_out)
	);

	// pick result and next flags by kind; unused codes pass operand_a through
	always_comb begin
		res_nxt   = a_s1;
		flags_nxt = flag_q;
		case (kind_s1) inside
			fsas_pkg::KIND_ADD, fsas_pkg::KIND_ADC,
			fsas_pkg::KIND_SUB, fsas_pkg::KIND_SBC: begin
				res_nxt   = alu_out.result;
				flags_nxt = alu_out.flags;
			end
			fsas_pkg::KIND_SHL, fsas_pkg::KIND_SHR, fsas_pkg::KIND_SAR,
			fsas_pkg::KIND_SHL_CC, fsas_pkg::KIND_SHR_CC,
			fsas_pkg::KIND_SAR_CC, fsas_pkg::KIND_ROR_CC: begin
				res_nxt = shift_out.result;
				if (shift_out.carry_we) begin
					flags_nxt.c = shift_out.carry;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flag_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				flag_q   <= flags_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= fsas_pkg::kind_t'(s_tuser);
			a_s1    <= s_tdata[W-1:0];
			b_s1    <= s_tdata[2*W-1:W];
		end
		if (advance) begin
			result_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;
	assign m_tuser  = flag_q;

`ifndef SYNTHESIS
	// input side only backs up when both stages are full and the output stalls
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("s_tready low without a full, stalled pipeline");

	// plain shifts never touch the flags
	a_plain_shift_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (kind_s1 == fsas_pkg::KIND_SHL || kind_s1 == fsas_pkg::KIND_SHR ||
		 kind_s1 == fsas_pkg::KIND_SAR)) |=> $stable(flag_q))
		else $error("plain shift changed the flags");

	// carry-setting shifts may touch C only
	a_cc_shift_nzv: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (kind_s1 == fsas_pkg::KIND_SHL_CC || kind_s1 == fsas_pkg::KIND_SHR_CC ||
		 kind_s1 == fsas_pkg::KIND_SAR_CC || kind_s1 == fsas_pkg::KIND_ROR_CC))
		|=> ($stable(flag_q.n) && $stable(flag_q.z) && $stable(flag_q.v)))
		else $error("carry-setting shift changed N, Z or V");

	// arithmetic results and their N/Z flags land together
	a_arith_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (kind_s1 == fsas_pkg::KIND_ADD || kind_s1 == fsas_pkg::KIND_ADC ||
		 kind_s1 == fsas_pkg::KIND_SUB || kind_s1 == fsas_pkg::KIND_SBC))
		|=> (m_tuser[0] == m_tdata[W-1] && m_tuser[1] == (m_tdata == '0)))
		else $error("N/Z flags disagree with arithmetic result");
`endif

endmodule
